@@ rtl/core/olsu_pkg.sv @@
// ----------------------------------------------------------------------------
// olsu_pkg
// shared types, codes and sizes of the ordered list store
// ----------------------------------------------------------------------------
package olsu_pkg;

	localparam int DEPTH    = 16;
	localparam int MAX_EMIT = 16;
	localparam int EMIT_N   = (DEPTH < MAX_EMIT) ? DEPTH : MAX_EMIT;
	localparam int FILL_W   = $clog2(DEPTH + 1);
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 8;
	localparam int ENTRY_W  = 5;

	typedef enum logic [2:0] {
		OP_FRONT      = 3'd0,
		OP_BACK       = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SORTED     = 3'd4,
		OP_AT_POS     = 3'd5,
		OP_READ_FWD   = 3'd6,
		OP_READ_BACK  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                    insert;
		logic                    sorted;
		logic                    shift;
		logic signed [VAL_W-1:0] value;
		logic [FILL_W-1:0]       ins_pos;
		logic [FILL_W-1:0]       fill;
	} cell_cmd_t;

endpackage

@@ rtl/core/olsu_cell.sv @@
// ----------------------------------------------------------------------------
// olsu_cell
// one slot of the list: holds a value, shifts toward either neighbor or loads
// ----------------------------------------------------------------------------
module olsu_cell (
	input  logic                              clk,
	input  olsu_pkg::cell_cmd_t               cmd,
	input  logic [olsu_pkg::IDX_W-1:0]        my_idx,
	input  logic                              first,
	input  logic                              before_in,
	output logic                              before_out,
	input  logic signed [olsu_pkg::VAL_W-1:0] left_in,
	input  logic signed [olsu_pkg::VAL_W-1:0] right_in,
	output logic signed [olsu_pkg::VAL_W-1:0] slot
);
	import olsu_pkg::*;

	logic signed [VAL_W-1:0] slot_q;
	logic                    valid;
	logic                    sorted_before;
	logic                    pos_before;
	logic                    stay;

	always_comb begin
		valid      = FILL_W'(my_idx) < cmd.fill;
		// head: stays ahead unless the new value is smaller
		// others: stay ahead while smaller than the new value
		if (first) begin
			sorted_before = valid && !(cmd.value < slot_q);
		end else begin
			sorted_before = before_in && valid && (slot_q < cmd.value);
		end
		pos_before = FILL_W'(my_idx) < cmd.ins_pos;
		stay       = cmd.sorted ? sorted_before : pos_before;
	end

	assign before_out = stay;
	assign slot       = slot_q;

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (!stay) begin
				slot_q <= before_in ? cmd.value : left_in;
			end
		end else if (cmd.shift) begin
			slot_q <= right_in;
		end
	end

endmodule

@@ rtl/core/ordered_list_store_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_store_unit
// bounded ordered list of signed values kept in a chain of shifting cells
// ----------------------------------------------------------------------------
// channel  dir  handshake                     contents
// s_axis   in   s_axis_tvalid/s_axis_tready   op in tuser, value and position
// m_axis   out  m_axis_tvalid/m_axis_tready   status in tuser, item/entries, tlast
//
// inserts and removes update the cells in parallel: each cell holds, shifts or loads
// a read sends up to 16 entries, one entry per cycle while the output is not held off
// no new item is taken while a read is sending entries
// a result waiting in the output register holds off input until it is taken;
// a new item can enter in the same cycle the waiting result is taken
// arst_n clears the entry count and handshake state; slot contents are not reset
// ----------------------------------------------------------------------------
module ordered_list_store_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // value[31:0], position[39:32]
	input  logic [2:0]  s_axis_tuser,   // op[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // item[31:0], entries[36:32], zero[39:37]
	output logic [1:0]  m_axis_tuser,   // status[1:0]
	output logic        m_axis_tlast
);
	import olsu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t                  state_q;
	logic [FILL_W-1:0]       fill_q;
	logic [FILL_W-1:0]       fill_d;
	logic [IDX_W-1:0]        cnt_q;
	logic [FILL_W-1:0]       num_q;
	logic                    rd_fwd_q;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic signed [VAL_W-1:0] out_item_q;
	logic [ENTRY_W-1:0]      out_entries_q;
	logic                    out_last_q;

	op_t                     op;
	logic signed [VAL_W-1:0] in_value;
	logic [POS_W-1:0]        in_pos;
	logic                    load_ok;
	logic                    acc;
	logic                    is_ins;
	logic                    is_pop;
	logic                    is_read;
	logic                    full;
	logic                    empty;
	logic                    rd_load;
	logic                    rd_last;
	logic [IDX_W-1:0]        rd_idx;
	cell_cmd_t               cmd;

	logic signed [VAL_W-1:0] slots [DEPTH];
	logic [DEPTH:0]          before_chain;

	assign op       = op_t'(s_axis_tuser);
	assign in_value = s_axis_tdata[31:0];
	assign in_pos   = s_axis_tdata[39:32];

	assign load_ok       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && load_ok;
	assign acc           = s_axis_tvalid && s_axis_tready;

	always_comb begin
		is_ins  = (op == OP_FRONT) || (op == OP_BACK) || (op == OP_SORTED) ||
		          (op == OP_AT_POS);
		is_pop  = (op == OP_POP_FRONT) || (op == OP_POP_BACK);
		is_read = (op == OP_READ_FWD) || (op == OP_READ_BACK);
		full    = fill_q == FILL_W'(DEPTH);
		empty   = fill_q == '0;

		cmd.insert = acc && is_ins && !full;
		cmd.sorted = op == OP_SORTED;
		cmd.shift  = acc && (op == OP_POP_FRONT) && !empty;
		cmd.value  = in_value;
		cmd.fill   = fill_q;
		case (op)
			OP_BACK:   cmd.ins_pos = fill_q;
			OP_AT_POS: cmd.ins_pos = (in_pos < POS_W'(fill_q)) ? FILL_W'(in_pos) : fill_q;
			default:   cmd.ins_pos = '0;
		endcase

		fill_d = fill_q;
		if (cmd.insert) begin
			fill_d = fill_q + FILL_W'(1);
		end else if (acc && is_pop && !empty) begin
			fill_d = fill_q - FILL_W'(1);
		end

		rd_load = (state_q == ST_READ) && load_ok;
		rd_last = (FILL_W'(cnt_q) + FILL_W'(1)) == num_q;
		rd_idx  = rd_fwd_q ? cnt_q : IDX_W'(fill_q - FILL_W'(1) - FILL_W'(cnt_q));
	end

	// chain of cells
	assign before_chain[0] = 1'b1;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;

		if (g == 0) begin : g_left_end
			assign left_v = '0;
		end else begin : g_left
			assign left_v = slots[g-1];
		end
		if (g == DEPTH - 1) begin : g_right_end
			assign right_v = '0;
		end else begin : g_right
			assign right_v = slots[g+1];
		end

		olsu_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.my_idx     (IDX_W'(g)),
			.first      (g == 0),
			.before_in  (before_chain[g]),
			.before_out (before_chain[g+1]),
			.left_in    (left_v),
			.right_in   (right_v),
			.slot       (slots[g])
		);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			num_q       <= '0;
			rd_fwd_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if ((acc && !(is_read && !empty)) || rd_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && is_read && !empty) begin
						state_q  <= ST_READ;
						cnt_q    <= '0;
						num_q    <= (fill_q < FILL_W'(EMIT_N)) ? fill_q : FILL_W'(EMIT_N);
						rd_fwd_q <= op == OP_READ_FWD;
					end
				end
				ST_READ: begin
					if (rd_load) begin
						cnt_q <= cnt_q + IDX_W'(1);
						if (rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (acc) begin
			out_item_q    <= '0;
			out_entries_q <= ENTRY_W'(fill_d);
			out_last_q    <= 1'b1;
			if (is_ins && full) begin
				out_status_q <= STAT_FULL;
			end else if ((is_pop || is_read) && empty) begin
				out_status_q <= STAT_EMPTY;
			end else begin
				out_status_q <= STAT_OK;
			end
		end else if (rd_load) begin
			out_item_q    <= slots[rd_idx];
			out_entries_q <= ENTRY_W'(fill_q);
			out_last_q    <= rd_last;
			out_status_q  <= STAT_OK;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_entries_q, out_item_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("entry count above depth");

	a_no_take_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !s_axis_tready)
		else $error("item taken during read");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_ins && full) |=> (fill_q == FILL_W'(DEPTH)))
		else $error("insert into full list changed count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("insert did not add one entry");

	a_read_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_load && rd_last) |=> (m_axis_tvalid && m_axis_tlast && state_q == ST_IDLE))
		else $error("read ended without final item");

endmodule
